// ===== src/line_pixel_stepper_assert.svh =====
// Assertion macros used by the line stepper top level.
`ifndef LINE_PIXEL_STEPPER_ASSERT_SVH
`define LINE_PIXEL_STEPPER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_pixel_stepper: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_pixel_stepper: next-cycle check failed");

`endif

// ===== src/lps_pkg.sv =====
// Shared constants and codes of the line pixel stepper.
package lps_pkg;

  localparam int LPS_COORD_BITS  = 12;
  localparam int LPS_REG_W       = 12;
  localparam int LPS_ADDR_W      = 22;
  localparam int LPS_CFG_IDX_W   = 1;
  localparam int LPS_QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [LPS_CFG_IDX_W-1:0] LPS_REG_FRAME_WIDTH  = 1'b0;
  localparam logic [LPS_CFG_IDX_W-1:0] LPS_REG_FRAME_HEIGHT = 1'b1;

  localparam logic [LPS_REG_W-1:0] LPS_FRAME_WIDTH_RST  = 12'd640;
  localparam logic [LPS_REG_W-1:0] LPS_FRAME_HEIGHT_RST = 12'd480;

  // Input command codes
  localparam logic LPS_CMD_START = 1'b0;
  localparam logic LPS_CMD_STEP  = 1'b1;

endpackage

// ===== src/line_pixel_stepper.sv =====
// Top level of the Bresenham line rasterizer with frame clipping.
//
// Line pixel stepper. A start command (in_tuser = 0) carries two endpoints and
// yields the first pixel of the line, taken from the end with the lower
// major-axis coordinate; each step command (in_tuser = 1) yields the next
// pixel. Every command gives exactly one result. A result carries x, y, a
// visible flag (0 <= x < frame_width and 0 <= y < frame_height), the linear
// address y*frame_width+x (zero when clipped, wraps to 22 bits) and tlast on
// the final pixel. A step with no line running returns an all-zero result.
// A start in the middle of a line drops the old one. Throughput is one
// command per clock while out_tready stays high, set by the error update in
// the stepper; an input transfer reaches the output through the setup
// register, queue, stepper stage and address multiply-add register. The queue
// lets setup continue for up to QUEUE_DEPTH commands while the output is stalled.
// Frame registers may only be written while the block is idle.
module line_pixel_stepper #(
  parameter int COORD_BITS  = lps_pkg::LPS_COORD_BITS,
  parameter int QUEUE_DEPTH = lps_pkg::LPS_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  // command channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata, LSB up: start_x, start_y, end_x, end_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]  in_tdata,
  // in_tuser: cmd
  input  logic                               in_tuser,
  // pixel channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, LSB up: pixel_x, pixel_y, frame_address, zero pad
  output logic [((2*COORD_BITS+lps_pkg::LPS_ADDR_W+7)/8)*8-1:0] out_tdata,
  // out_tuser, LSB up: pixel_valid, visible
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  // frame register writes
  input  logic                               cfg_we,
  input  logic [lps_pkg::LPS_CFG_IDX_W-1:0]  cfg_index,
  input  logic [lps_pkg::LPS_REG_W-1:0]      cfg_wdata
);

  `include "line_pixel_stepper_assert.svh"

  localparam int CB  = COORD_BITS;
  localparam int EW  = CB + 3;
  localparam int AW  = lps_pkg::LPS_ADDR_W;
  localparam int TDW = ((2*CB+AW+7)/8)*8;
  localparam int OUT_PV_BIT  = 0;
  localparam int OUT_VIS_BIT = 1;

  // set-up line for the stepper
  typedef struct packed {
    logic                 is_start;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] major_end;
    logic signed [EW-1:0] err;
    logic signed [EW-1:0] minor_inc;
    logic signed [EW-1:0] both_inc;
    logic                 steep;
    logic                 dir_up;
    logic                 active;
  } lps_cmd_t;

  // stepped pixel before clipping
  typedef struct packed {
    logic                 on;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 last;
  } lps_pix_t;

  logic [lps_pkg::LPS_REG_W-1:0] frame_width_r, frame_width_nxt;
  logic [lps_pkg::LPS_REG_W-1:0] frame_height_r, frame_height_nxt;

  logic     f_vld, f_rdy;
  lps_cmd_t f_data;
  logic     q_vld, q_rdy;
  lps_cmd_t q_data;
  logic     pix_vld, pix_rdy;
  lps_pix_t pix_data;

  logic          o_on, o_vis;
  logic [CB-1:0] o_x, o_y;
  logic [AW-1:0] o_addr;
  logic          o_last_w;

  // frame registers
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lps_pkg::LPS_REG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata;
        lps_pkg::LPS_REG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lps_pkg::LPS_FRAME_WIDTH_RST;
      frame_height_r <= lps_pkg::LPS_FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // setup: deltas, major axis, initial error
  lps_front #(
    .COORD_BITS (COORD_BITS),
    .cmd_t      (lps_cmd_t)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_tvalid),
    .in_rdy   (in_tready),
    .in_cmd   (in_tuser),
    .in_x1    (in_tdata[CB-1:0]),
    .in_y1    (in_tdata[2*CB-1:CB]),
    .in_x2    (in_tdata[3*CB-1:2*CB]),
    .in_y2    (in_tdata[4*CB-1:3*CB]),
    .cmd_vld  (f_vld),
    .cmd_rdy  (f_rdy),
    .cmd_data (f_data)
  );

  // decouples setup from the stepper and output
  lps_queue #(
    .entry_t (lps_cmd_t),
    .DEPTH   (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (f_vld),
    .push_rdy  (f_rdy),
    .push_data (f_data),
    .pop_vld   (q_vld),
    .pop_rdy   (q_rdy),
    .pop_data  (q_data)
  );

  // line state and per-pixel error update
  lps_back #(
    .COORD_BITS (COORD_BITS),
    .cmd_t      (lps_cmd_t),
    .pix_t      (lps_pix_t)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (q_vld),
    .cmd_rdy  (q_rdy),
    .cmd_data (q_data),
    .pix_vld  (pix_vld),
    .pix_rdy  (pix_rdy),
    .pix_data (pix_data)
  );

  // clip, address and output register
  lps_emit #(
    .COORD_BITS (COORD_BITS),
    .pix_t      (lps_pix_t)
  ) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_vld      (pix_vld),
    .pix_rdy      (pix_rdy),
    .pix_data     (pix_data),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .out_vld      (out_tvalid),
    .out_rdy      (out_tready),
    .out_on       (o_on),
    .out_x        (o_x),
    .out_y        (o_y),
    .out_vis      (o_vis),
    .out_addr     (o_addr),
    .out_last     (o_last_w)
  );

  assign out_tdata = TDW'({o_addr, o_y, o_x});
  assign out_tuser = {o_vis, o_on};
  assign out_tlast = o_last_w;

  // a visible pixel is always a real one
  `LPS_ASSERT_IMP(a_vis_is_pixel, out_tvalid && out_tuser[OUT_VIS_BIT], out_tuser[OUT_PV_BIT])
  // a visible pixel never has a negative coordinate
  `LPS_ASSERT_IMP(a_vis_nonneg, out_tvalid && out_tuser[OUT_VIS_BIT], !o_x[CB-1] && !o_y[CB-1])
  // an empty result carries nothing
  `LPS_ASSERT_IMP(a_empty_zero, out_tvalid && !out_tuser[OUT_PV_BIT], (out_tdata == '0) && !out_tlast)
  // each transfer out of the queue lands in the stepper stage
  `LPS_ASSERT_NXT(a_pop_fills_stage, q_vld && q_rdy, pix_vld)

endmodule

// ===== src/lps_queue.sv =====
// Small flop-based FIFO between the classifier front and the stepper back.
module lps_queue #(
  parameter type entry_t = logic,
  parameter int  DEPTH   = lps_pkg::LPS_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_vld,
  output logic   push_rdy,
  input  entry_t push_data,
  output logic   pop_vld,
  input  logic   pop_rdy,
  output entry_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_rdy = (count_r != CW'(DEPTH));
  assign pop_vld  = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/lps_front.sv =====
// Front end: accepts commands, takes endpoint deltas and sets up the line walk.
module lps_front #(
  parameter int  COORD_BITS = lps_pkg::LPS_COORD_BITS,
  parameter type cmd_t      = logic
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  logic                  in_cmd,
  input  logic [COORD_BITS-1:0] in_x1,
  input  logic [COORD_BITS-1:0] in_y1,
  input  logic [COORD_BITS-1:0] in_x2,
  input  logic [COORD_BITS-1:0] in_y2,
  output logic                  cmd_vld,
  input  logic                  cmd_rdy,
  output cmd_t                  cmd_data
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int EW = CB + 3;

  logic                 v1_r, v1_nxt;
  logic                 st1_r;
  logic signed [CB-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [CB-1:0] sx1, sy1, sx2, sy2;
  logic                 in_fire;

  // classification
  logic [DW-1:0]        ax, ay;
  logic signed [EW-1:0] e_min, e_maj;
  logic                 steep, first_is_start, dir_up;

  assign sx1 = $signed(in_x1);
  assign sy1 = $signed(in_y1);
  assign sx2 = $signed(in_x2);
  assign sy2 = $signed(in_y2);

  assign in_rdy  = !v1_r || cmd_rdy;
  assign in_fire = in_vld && in_rdy;
  assign cmd_vld = v1_r;

  always_comb begin
    v1_nxt = v1_r;
    if (in_fire) begin
      v1_nxt = 1'b1;
    end else if (cmd_rdy) begin
      v1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st1_r <= (in_cmd == lps_pkg::LPS_CMD_START);
      x1_r  <= sx1;
      y1_r  <= sy1;
      x2_r  <= sx2;
      y2_r  <= sy2;
      dx_r  <= DW'(sx2) - DW'(sx1);
      dy_r  <= DW'(sy2) - DW'(sy1);
    end
  end

  always_comb begin
    ax     = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
    ay     = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
    steep  = (ay > ax);
    dir_up = (dx_r[DW-1] && dy_r[DW-1]) ||
             (!dx_r[DW-1] && (dx_r != '0) && !dy_r[DW-1] && (dy_r != '0));
    e_min  = steep ? $signed(EW'(ax)) : $signed(EW'(ay));
    e_maj  = steep ? $signed(EW'(ay)) : $signed(EW'(ax));
    first_is_start = steep ? !dy_r[DW-1] : !dx_r[DW-1];

    cmd_data           = '0;
    cmd_data.is_start  = st1_r;
    cmd_data.steep     = steep;
    cmd_data.dir_up    = dir_up;
    cmd_data.err       = (e_min <<< 1) - e_maj;
    cmd_data.minor_inc = e_min <<< 1;
    cmd_data.both_inc  = (e_min - e_maj) <<< 1;
    cmd_data.x         = first_is_start ? x1_r : x2_r;
    cmd_data.y         = first_is_start ? y1_r : y2_r;
    if (steep) begin
      cmd_data.major_end = first_is_start ? y2_r : y1_r;
    end else begin
      cmd_data.major_end = first_is_start ? x2_r : x1_r;
    end
    // walk starts at the lower major end, so it runs on iff the major delta is nonzero
    cmd_data.active = steep ? (dy_r != '0) : (dx_r != '0);
  end

endmodule

// ===== src/lps_back.sv =====
// Back end: holds the line state and advances one pixel per step command.
module lps_back #(
  parameter int  COORD_BITS = lps_pkg::LPS_COORD_BITS,
  parameter type cmd_t      = logic,
  parameter type pix_t      = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_vld,
  output logic cmd_rdy,
  input  cmd_t cmd_data,
  output logic pix_vld,
  input  logic pix_rdy,
  output pix_t pix_data
);

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 3;

  logic signed [CB-1:0] cur_x_r, cur_x_nxt;
  logic signed [CB-1:0] cur_y_r, cur_y_nxt;
  logic signed [CB-1:0] major_end_r, major_end_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic signed [EW-1:0] minor_inc_r, minor_inc_nxt;
  logic signed [EW-1:0] both_inc_r, both_inc_nxt;
  logic                 steep_r, steep_nxt;
  logic                 dir_up_r, dir_up_nxt;
  logic                 active_r, active_nxt;
  logic                 pv_r, pv_nxt;
  pix_t                 pix_r, pix_nxt;

  logic                 pop;
  logic signed [CB-1:0] x_n, y_n, mstep;
  logic signed [EW-1:0] err_n;
  logic                 hold, act_n;

  assign cmd_rdy  = !pv_r || pix_rdy;
  assign pop      = cmd_vld && cmd_rdy;
  assign pix_vld  = pv_r;
  assign pix_data = pix_r;

  // one Bresenham step from the current state
  always_comb begin
    mstep = dir_up_r ? CB'(1) : '1;
    x_n   = cur_x_r;
    y_n   = cur_y_r;
    if (!steep_r) begin
      x_n   = cur_x_r + CB'(1);
      hold  = err_r[EW-1];
      if (!hold) begin
        y_n = cur_y_r + mstep;
      end
      act_n = (x_n < major_end_r);
    end else begin
      y_n   = cur_y_r + CB'(1);
      hold  = err_r[EW-1] || (err_r == '0);
      if (!hold) begin
        x_n = cur_x_r + mstep;
      end
      act_n = (y_n < major_end_r);
    end
    err_n = hold ? err_r + minor_inc_r : err_r + both_inc_r;
  end

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    major_end_nxt = major_end_r;
    err_nxt       = err_r;
    minor_inc_nxt = minor_inc_r;
    both_inc_nxt  = both_inc_r;
    steep_nxt     = steep_r;
    dir_up_nxt    = dir_up_r;
    active_nxt    = active_r;
    pix_nxt       = pix_r;
    pv_nxt        = pv_r;
    if (pop) begin
      pv_nxt = 1'b1;
      if (cmd_data.is_start) begin
        cur_x_nxt     = cmd_data.x;
        cur_y_nxt     = cmd_data.y;
        major_end_nxt = cmd_data.major_end;
        err_nxt       = cmd_data.err;
        minor_inc_nxt = cmd_data.minor_inc;
        both_inc_nxt  = cmd_data.both_inc;
        steep_nxt     = cmd_data.steep;
        dir_up_nxt    = cmd_data.dir_up;
        active_nxt    = cmd_data.active;
        pix_nxt.on    = 1'b1;
        pix_nxt.x     = cmd_data.x;
        pix_nxt.y     = cmd_data.y;
        pix_nxt.last  = !cmd_data.active;
      end else if (active_r) begin
        cur_x_nxt    = x_n;
        cur_y_nxt    = y_n;
        err_nxt      = err_n;
        active_nxt   = act_n;
        pix_nxt.on   = 1'b1;
        pix_nxt.x    = x_n;
        pix_nxt.y    = y_n;
        pix_nxt.last = !act_n;
      end else begin
        // step with no line running: empty result
        pix_nxt = '0;
      end
    end else if (pix_rdy) begin
      pv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      steep_r  <= 1'b0;
      dir_up_r <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      steep_r  <= steep_nxt;
      dir_up_r <= dir_up_nxt;
      pv_r     <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    major_end_r <= major_end_nxt;
    err_r       <= err_nxt;
    minor_inc_r <= minor_inc_nxt;
    both_inc_r  <= both_inc_nxt;
    pix_r       <= pix_nxt;
  end

endmodule

// ===== src/lps_emit.sv =====
// Output stage: clip test, frame address multiply-add and the result register.
module lps_emit #(
  parameter int  COORD_BITS = lps_pkg::LPS_COORD_BITS,
  parameter type pix_t      = logic
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pix_vld,
  output logic                          pix_rdy,
  input  pix_t                          pix_data,
  input  logic [lps_pkg::LPS_REG_W-1:0] frame_width,
  input  logic [lps_pkg::LPS_REG_W-1:0] frame_height,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output logic                          out_on,
  output logic [COORD_BITS-1:0]         out_x,
  output logic [COORD_BITS-1:0]         out_y,
  output logic                          out_vis,
  output logic [lps_pkg::LPS_ADDR_W-1:0] out_addr,
  output logic                          out_last
);

  localparam int CB = COORD_BITS;
  localparam int RW = lps_pkg::LPS_REG_W;
  localparam int AW = lps_pkg::LPS_ADDR_W;
  localparam int MW = (CB > RW) ? CB : RW;
  localparam int PW = (CB + RW + 1 > AW) ? CB + RW + 1 : AW;

  logic          ov_r, ov_nxt;
  logic          on_r, vis_r, last_r;
  logic [CB-1:0] x_r, y_r;
  logic [AW-1:0] addr_r;
  logic          vis;
  logic [PW-1:0] addr_full;

  assign pix_rdy = !ov_r || out_rdy;

  always_comb begin
    vis = pix_data.on && !pix_data.x[CB-1] && !pix_data.y[CB-1] &&
          (MW'(pix_data.x) < MW'(frame_width)) &&
          (MW'(pix_data.y) < MW'(frame_height));
    addr_full = PW'(pix_data.y) * PW'(frame_width) + PW'(pix_data.x);
  end

  always_comb begin
    ov_nxt = ov_r;
    if (pix_vld && pix_rdy) begin
      ov_nxt = 1'b1;
    end else if (out_rdy) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_vld && pix_rdy) begin
      on_r   <= pix_data.on;
      x_r    <= pix_data.x;
      y_r    <= pix_data.y;
      last_r <= pix_data.last;
      vis_r  <= vis;
      addr_r <= vis ? addr_full[AW-1:0] : '0;
    end
  end

  assign out_vld  = ov_r;
  assign out_on   = on_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_vis  = vis_r;
  assign out_addr = addr_r;
  assign out_last = last_r;

endmodule
